>>> hdl/sol_pkg.sv
// ----------------------------------------------------------------------------
// sol_pkg: shared types for the shifting ordered list
// Defines the command, status, cell operation and controller state codes and
// the stored entry format. The cells and the top level both use these.
// ----------------------------------------------------------------------------
package sol_pkg;

    // Width of each field carried on the streams.
    localparam int CmdW   = 3;
    localparam int PosW   = 5;
    localparam int KeyW   = 8;
    localparam int PayW   = 32;
    localparam int StatW  = 3;
    localparam int CountW = 5;

    // Packed stream widths, rounded up to whole bytes, and the used output width.
    localparam int InDataW  = 48;
    localparam int OutDataW = 56;
    localparam int OutUsedW = StatW + PosW + KeyW + PayW + CountW;

    // Command codes as they arrive in the request.
    typedef enum logic [CmdW-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_REMOVE_END = 3'd2,
        CMD_REMOVE_AT  = 3'd3,
        CMD_SEARCH     = 3'd4
    } t_cmd;

    // Result status codes.
    typedef enum logic [StatW-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BAD_POS  = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        COP_HOLD    = 2'd0,
        COP_INSERT  = 2'd1,
        COP_DELETE  = 2'd2,
        COP_COMPARE = 2'd3
    } t_cell_op;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // One stored entry.
    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [PayW-1:0] payload;
    } t_entry;

endpackage

>>> hdl/sol_cell.sv
// ----------------------------------------------------------------------------
// sol_cell: one slot of the list
// Holds one entry. On a broadcast insert it loads the new entry or takes its
// left neighbor; on a delete it takes its right neighbor; on a compare it
// registers whether its key matches the searched key.
// ----------------------------------------------------------------------------
module sol_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                            i_clk,
    input  sol_pkg::t_cell_op               i_op,
    input  logic [$clog2(DEPTH)-1:0]        i_tgt,
    input  sol_pkg::t_entry                 i_new,
    input  sol_pkg::t_entry                 i_left,
    input  sol_pkg::t_entry                 i_right,
    input  logic [sol_pkg::KeyW-1:0]        i_key,
    output sol_pkg::t_entry                 o_entry,
    output logic                            o_match
);
    import sol_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MyIdx = IW'(IDX);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_match;

    // Next content of this slot.
    always_comb begin
        n_entry = r_entry;
        case (i_op)
            COP_INSERT: begin
                if (MyIdx == i_tgt) begin
                    n_entry = i_new;
                end else if (MyIdx > i_tgt) begin
                    n_entry = i_left;
                end
            end
            COP_DELETE: begin
                if (MyIdx >= i_tgt) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Slot content and match flag; neither needs a reset. The match flag is
    // held after a compare so that it survives a stalled result.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_op == COP_COMPARE) begin
            r_match <= (r_entry.key == i_key);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

>>> hdl/shifting_ordered_list.sv
// Requests are handled one at a time; the controller steps through capture,
// cell-row update and result select for each request in turn, and a result
// stalled by the receiver holds the controller in result select.
// Reset: i_rst_n is synchronous and active low; it empties the list and drops
// a pending result. Slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// shifting_ordered_list: left-packed list held in a row of cells
// Commands append, insert at a position, remove the last entry, remove at a
// position, or search for the first position holding a key. Insert and
// remove shift every later cell by one place in a single update of the row.
// ----------------------------------------------------------------------------
module shifting_ordered_list #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] cmd, [7:3] position, [15:8] entry_key, [47:16] entry_payload
    input  logic [sol_pkg::InDataW-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] status, [7:3] found_position, [15:8] out_key,
    // [47:16] out_payload, [52:48] entry_count, [55:53] zero
    output logic [sol_pkg::OutDataW-1:0]     m_axis_tdata
);
    import sol_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > PosW) ? CW : PosW) + 1;
    localparam logic [CW-1:0] FullCount = CW'(DEPTH);

    t_state r_state;
    t_state n_state;

    // Captured request.
    logic [CmdW-1:0] r_cmd;
    logic [PosW-1:0] r_pos;
    t_entry          r_new;

    // List bookkeeping and execute results.
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   c_fill;
    t_status         r_status;
    t_status         c_status;
    logic            r_take;
    logic            c_take;
    logic            r_search;
    t_entry          r_rem;

    // Cell row broadcast.
    t_cell_op        c_op;
    logic [IW-1:0]   c_tgt;
    t_entry          w_cell  [DEPTH];
    logic [DEPTH-1:0] w_match;

    // Search resolve.
    logic            c_hit_any;
    logic [IW-1:0]   c_hit_idx;

    // Output register.
    logic                r_out_valid;
    logic [StatW-1:0]    r_out_status;
    logic [PosW-1:0]     r_out_found;
    t_entry              r_out_entry;
    logic [CountW-1:0]   r_out_count;
    logic                c_out_load;

    logic [WW-1:0]   w_pos_x;
    logic [WW-1:0]   w_fill_x;

    assign w_pos_x  = WW'(r_pos);
    assign w_fill_x = WW'(r_fill);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs: request ready, command checks and cell broadcast.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE) && i_rst_n;
        c_out_load    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
        c_op     = COP_HOLD;
        c_tgt    = '0;
        c_status = ST_OK;
        c_fill   = r_fill;
        c_take   = 1'b0;
        if (r_state == S_EXEC) begin
            case (r_cmd)
                CMD_APPEND: begin
                    if (r_fill == FullCount) begin
                        c_status = ST_FULL;
                    end else begin
                        c_op   = COP_INSERT;
                        c_tgt  = IW'(r_fill);
                        c_fill = r_fill + CW'(1);
                    end
                end
                CMD_INSERT: begin
                    if (r_fill == FullCount) begin
                        c_status = ST_FULL;
                    end else if (w_pos_x == '0 || w_pos_x > w_fill_x + WW'(1)) begin
                        c_status = ST_BAD_POS;
                    end else begin
                        c_op   = COP_INSERT;
                        c_tgt  = IW'(w_pos_x - WW'(1));
                        c_fill = r_fill + CW'(1);
                    end
                end
                CMD_REMOVE_END: begin
                    if (r_fill == '0) begin
                        c_status = ST_EMPTY;
                    end else begin
                        c_op   = COP_DELETE;
                        c_tgt  = IW'(r_fill - CW'(1));
                        c_fill = r_fill - CW'(1);
                        c_take = 1'b1;
                    end
                end
                CMD_REMOVE_AT: begin
                    if (r_fill == '0) begin
                        c_status = ST_EMPTY;
                    end else if (w_pos_x == '0 || w_pos_x > w_fill_x) begin
                        c_status = ST_BAD_POS;
                    end else begin
                        c_op   = COP_DELETE;
                        c_tgt  = IW'(w_pos_x - WW'(1));
                        c_fill = r_fill - CW'(1);
                        c_take = 1'b1;
                    end
                end
                CMD_SEARCH: begin
                    c_op = COP_COMPARE;
                end
                default: begin
                    c_op = COP_HOLD;
                end
            endcase
        end
    end

    // Row of cells; each takes its neighbors' contents on a shift.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_first
            assign w_left = r_new;
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end
        sol_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (c_op),
            .i_tgt   (c_tgt),
            .i_new   (r_new),
            .i_left  (w_left),
            .i_right (w_right),
            .i_key   (r_new.key),
            .o_entry (w_cell[g]),
            .o_match (w_match[g])
        );
    end

    // First occupied cell whose key matched.
    always_comb begin
        c_hit_any = 1'b0;
        c_hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i] && (CW'(i) < r_fill)) begin
                c_hit_any = 1'b1;
                c_hit_idx = IW'(i);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_fill <= c_fill;
            end
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and execute results.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd         <= s_axis_tdata[2:0];
            r_pos         <= s_axis_tdata[7:3];
            r_new.key     <= s_axis_tdata[15:8];
            r_new.payload <= s_axis_tdata[47:16];
        end
        if (r_state == S_EXEC) begin
            r_status <= c_status;
            r_take   <= c_take;
            r_search <= (r_cmd == CMD_SEARCH);
            r_rem    <= w_cell[c_tgt];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_out_count <= CountW'(r_fill);
            if (r_search) begin
                if (c_hit_any) begin
                    r_out_status <= ST_OK;
                    r_out_found  <= PosW'(WW'(c_hit_idx) + WW'(1));
                    r_out_entry  <= w_cell[c_hit_idx];
                end else begin
                    r_out_status <= ST_NOTFOUND;
                    r_out_found  <= '0;
                    r_out_entry  <= '0;
                end
            end else begin
                r_out_status <= r_status;
                r_out_found  <= '0;
                r_out_entry  <= r_take ? r_rem : '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), r_out_count,
                            r_out_entry.payload, r_out_entry.key,
                            r_out_found, r_out_status};

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for shifting_ordered_list
// A queue of list commands is built at time zero: a short directed opening
// that walks the empty, bad position, not found and unused-code cases,
// then random episodes that grow, shrink and churn the list with mostly
// legal positions and a small key set so that searches hit duplicates. A
// clocked driver offers the commands in bursts, a clocked monitor checks each
// result against an in-bench copy of the list, and the receiver stalls in
// changing patterns, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import sol_pkg::*;

    localparam int DEPTH = 16;

    // Unused command codes; the block treats them as no-ops.
    localparam logic [CmdW-1:0] CMD_NOOP_FIRST = 3'd5;
    localparam logic [CmdW-1:0] CMD_NOOP_LAST  = 3'd7;

    // Run control.
    localparam int RANDOM_CMDS    = 1200;
    localparam int HOLD_START     = 500;
    localparam int HOLD_CYCLES    = 150;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 12;

    // Request fields, cmd in the lowest bits.
    typedef struct packed {
        logic [PayW-1:0] payload;
        logic [KeyW-1:0] key;
        logic [PosW-1:0] pos;
        logic [CmdW-1:0] cmd;
    } t_list_req;

    // Result fields, status in the lowest bits.
    typedef struct packed {
        logic [OutDataW-OutUsedW-1:0] pad;
        logic [CountW-1:0]            count;
        logic [PayW-1:0]              payload;
        logic [KeyW-1:0]              key;
        logic [PosW-1:0]              found;
        logic [StatW-1:0]             status;
    } t_list_rsp;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_STEADY, RX_COIN, RX_MOSTLY, RX_SPARSE
    } t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;

    // Commands waiting to be offered, and results the list owes us.
    t_list_req pending_reqs[$];
    t_list_rsp expected_rsps[$];

    // Shadow copy of the list.
    t_entry list_slots[DEPTH];
    int     list_count = 0;

    int fail_count = 0;
    int cmds_sent = 0;
    int noops_sent = 0;
    int input_stalls = 0;
    int status_seen[5];

    shifting_ordered_list #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the shadow list and return the result it owes.
    function automatic t_list_rsp list_apply(t_list_req req);
        t_list_rsp rsp;
        int        pos;
        rsp = '0;
        pos = req.pos;
        case (req.cmd)
            CMD_APPEND, CMD_INSERT: begin
                if (list_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    if (req.cmd == CMD_APPEND) pos = list_count + 1;
                    if (pos < 1 || pos > list_count + 1) begin
                        rsp.status = ST_BAD_POS;
                    end else begin
                        for (int j = list_count; j >= pos; j--)
                            list_slots[j] = list_slots[j-1];
                        list_slots[pos-1].key     = req.key;
                        list_slots[pos-1].payload = req.payload;
                        list_count++;
                    end
                end
            end
            CMD_REMOVE_END, CMD_REMOVE_AT: begin
                if (list_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    if (req.cmd == CMD_REMOVE_END) pos = list_count;
                    if (pos < 1 || pos > list_count) begin
                        rsp.status = ST_BAD_POS;
                    end else begin
                        rsp.key     = list_slots[pos-1].key;
                        rsp.payload = list_slots[pos-1].payload;
                        for (int j = pos; j < list_count; j++)
                            list_slots[j-1] = list_slots[j];
                        list_count--;
                    end
                end
            end
            CMD_SEARCH: begin
                rsp.status = ST_NOTFOUND;
                for (int j = 0; j < list_count; j++) begin
                    if (rsp.status == ST_NOTFOUND && list_slots[j].key == req.key) begin
                        rsp.status  = ST_OK;
                        rsp.found   = PosW'(j + 1);
                        rsp.key     = list_slots[j].key;
                        rsp.payload = list_slots[j].payload;
                    end
                end
            end
            default: ;
        endcase
        rsp.count = CountW'(list_count);
        return rsp;
    endfunction

    // Entry count after a command, for steering the generator.
    function automatic int count_after(t_list_req req, int cnt);
        case (req.cmd)
            CMD_APPEND:     if (cnt < DEPTH) return cnt + 1;
            CMD_INSERT:     if (cnt < DEPTH && req.pos >= 1 && req.pos <= cnt + 1) return cnt + 1;
            CMD_REMOVE_END: if (cnt > 0) return cnt - 1;
            CMD_REMOVE_AT:  if (cnt > 0 && req.pos >= 1 && req.pos <= cnt) return cnt - 1;
            default: ;
        endcase
        return cnt;
    endfunction

    function automatic t_list_req make_req(logic [CmdW-1:0] cmd, int pos, int key,
                                           logic [PayW-1:0] payload);
        t_list_req req;
        req.cmd     = cmd;
        req.pos     = PosW'(pos);
        req.key     = KeyW'(key);
        req.payload = payload;
        return req;
    endfunction

    // Mostly a small key set so that searches hit and keys repeat.
    function automatic int pick_key();
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, 7);
        return $urandom_range(0, 255);
    endfunction

    // Mostly a legal position for the current fill, sometimes anything.
    function automatic int pick_pos(int lo, int hi);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 31);
        return $urandom_range(lo, (hi < lo) ? lo : hi);
    endfunction

    function automatic void check_field(string name, logic [PayW-1:0] exp_val,
                                        logic [PayW-1:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            fail_count++;
        end
    endfunction

    // Build the stimulus, release reset, wait for the list to drain.
    initial begin
        t_list_req req;
        int        gen_count;
        int        gen_total;
        int        flavor;
        int        span;
        int        roll;

        // Empty-list cases, then bad and good inserts.
        pending_reqs.push_back(make_req(CMD_REMOVE_END, 0, 0, '0));
        pending_reqs.push_back(make_req(CMD_REMOVE_AT, 1, 0, '0));
        pending_reqs.push_back(make_req(CMD_SEARCH, 0, 3, '0));
        pending_reqs.push_back(make_req(CMD_INSERT, 0, 1, 32'h1111_1111));
        pending_reqs.push_back(make_req(CMD_INSERT, 2, 1, 32'h1111_1111));
        pending_reqs.push_back(make_req(CMD_INSERT, 1, 255, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(CMD_APPEND, 31, 0, 32'h0000_0000));
        pending_reqs.push_back(make_req(CMD_INSERT, 1, 8'h55, 32'hAAAA_5555));
        pending_reqs.push_back(make_req(CMD_INSERT, 4, 8'hAA, 32'h5555_AAAA));
        pending_reqs.push_back(make_req(CMD_APPEND, 0, 0, 32'h0BAD_F00D));
        // Bad remove positions, searches, unused codes.
        pending_reqs.push_back(make_req(CMD_REMOVE_AT, 0, 0, '0));
        pending_reqs.push_back(make_req(CMD_REMOVE_AT, 6, 0, '0));
        pending_reqs.push_back(make_req(CMD_REMOVE_AT, 31, 0, '0));
        pending_reqs.push_back(make_req(CMD_SEARCH, 0, 0, '0));
        pending_reqs.push_back(make_req(CMD_SEARCH, 0, 8'h12, '0));
        for (int c = CMD_NOOP_FIRST; c <= CMD_NOOP_LAST; c++)
            pending_reqs.push_back(make_req(CmdW'(c), 31, 255, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(CMD_REMOVE_AT, 2, 0, '0));
        pending_reqs.push_back(make_req(CMD_REMOVE_AT, 1, 0, '0));
        pending_reqs.push_back(make_req(CMD_REMOVE_END, 0, 0, '0));
        pending_reqs.push_back(make_req(CMD_SEARCH, 0, 255, '0));

        gen_count = 0;
        foreach (pending_reqs[i]) gen_count = count_after(pending_reqs[i], gen_count);

        // Random episodes: grow, shrink, churn, or raw noise. The first one
        // always grows so that the full cases come early.
        gen_total = 0;
        flavor = 0;
        while (gen_total < RANDOM_CMDS) begin
            span = $urandom_range(8, 40);
            for (int n = 0; n < span; n++) begin
                roll = $urandom_range(0, 99);
                if (flavor == 3) begin
                    req = make_req(CmdW'($urandom_range(0, 7)), $urandom_range(0, 31),
                                   $urandom_range(0, 255), $urandom());
                end else if (roll < (flavor == 0 ? 60 : flavor == 1 ? 15 : 35)) begin
                    if ($urandom_range(0, 1) == 0)
                        req = make_req(CMD_APPEND, $urandom_range(0, 31), pick_key(),
                                       $urandom());
                    else
                        req = make_req(CMD_INSERT, pick_pos(1, gen_count + 1), pick_key(),
                                       $urandom());
                end else if (roll < (flavor == 0 ? 75 : flavor == 1 ? 75 : 65)) begin
                    if ($urandom_range(0, 1) == 0)
                        req = make_req(CMD_REMOVE_END, $urandom_range(0, 31), pick_key(),
                                       $urandom());
                    else
                        req = make_req(CMD_REMOVE_AT, pick_pos(1, gen_count), pick_key(),
                                       $urandom());
                end else if (roll < 95) begin
                    req = make_req(CMD_SEARCH, $urandom_range(0, 31), pick_key(), $urandom());
                end else begin
                    req = make_req(CmdW'($urandom_range(0, 7)), $urandom_range(0, 31),
                                   $urandom_range(0, 255), $urandom());
                end
                pending_reqs.push_back(req);
                gen_count = count_after(req, gen_count);
                if (req.cmd <= CMD_SEARCH) gen_total++;
            end
            flavor = $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d list commands and %0d unused codes; input held back %0d cycles.",
                 cmds_sent, noops_sent, input_stalls);
        $display("Results: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_BAD_POS], status_seen[ST_NOTFOUND]);
        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Request driver: bursts of commands with random gaps between them.
    always @(posedge i_clk) begin : req_driver
        int  burst_left;
        int  gap_left;
        bit  holding;
        t_list_req sent;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            holding = s_axis_tvalid;
            if (s_axis_tvalid && !s_axis_tready) input_stalls++;
            if (s_axis_tvalid && s_axis_tready) begin
                sent = pending_reqs.pop_front();
                expected_rsps.push_back(list_apply(sent));
                if (sent.cmd <= CMD_SEARCH) cmds_sent++;
                else noops_sent++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_reqs[0];
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                                : $urandom_range(1, 16);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: changing stall patterns and one long hold-off.
    always @(posedge i_clk) begin : rsp_pacer
        int       rx_cycle;
        int       hold_left;
        int       mode_left;
        t_rx_mode mode;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_cycle  = 0;
            hold_left = 0;
            mode_left = 0;
            mode      = RX_STEADY;
        end else begin
            rx_cycle++;
            if (rx_cycle == HOLD_START) hold_left = HOLD_CYCLES;
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_STEADY: m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= $urandom_range(0, 1) == 1;
                    RX_MOSTLY: m_axis_tready <= $urandom_range(0, 3) != 0;
                    default:   m_axis_tready <= $urandom_range(0, 4) == 0;
                endcase
            end
        end
    end

    // Result monitor: compare each result with the oldest expectation.
    always @(posedge i_clk) begin : rsp_monitor
        t_list_rsp got;
        t_list_rsp exp_rsp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_list_rsp'(m_axis_tdata);
            if (expected_rsps.size() == 0) begin
                $error("Unexpected result 0x%0h with no command outstanding", m_axis_tdata);
                fail_count++;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                status_seen[exp_rsp.status]++;
                check_field("status", exp_rsp.status, got.status);
                check_field("found_position", exp_rsp.found, got.found);
                check_field("out_key", exp_rsp.key, got.key);
                check_field("out_payload", exp_rsp.payload, got.payload);
                check_field("entry_count", exp_rsp.count, got.count);
                check_field("pad", exp_rsp.pad, got.pad);
            end
        end
    end

    // Watchdog: give up when nothing moves for too long.
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog expired: %0d commands pending, %0d results owed.",
                         pending_reqs.size(), expected_rsps.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
